/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for clocked concurrent assertions with synchronous reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define NSR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after antecedent
`define NSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// consequent must hold in the same cycle as antecedent
`define NSR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define NSR_ASSERT(lbl, clk, rst, prop, msg)
`define NSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define NSR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/nsr_pkg.sv */
// ----------------------------------------------------------------------------
// nsr_pkg
// shared types and constants of the newton square root unit
// ----------------------------------------------------------------------------
`default_nettype none

package nsr_pkg;

  localparam int ITER_W = 6;
  localparam logic [ITER_W-1:0] ITER_RESET = 6'd30;

  // status of the shared divider seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

/* rtl/newton_square_root_unit.sv */
// ----------------------------------------------------------------------------
// newton_square_root_unit
// unsigned fixed-point square root by repeated newton steps on a shared divider
// ----------------------------------------------------------------------------
// One radicand (unsigned, FRACTION_BITS fraction bits) is taken per transaction and
// one root is returned. Starting from 1.0 the unit applies estimate = (estimate +
// radicand / estimate) / 2 iteration_count times (30 after reset), then saturates
// the estimate to the root width. Every step runs through a single bit-serial
// divider producing one quotient bit per clock. s_tready is low while an item is
// in work; a finished root waits in the output register and the next radicand may
// be taken meanwhile. iteration_count is written through the cfg channel only
// while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module newton_square_root_unit import nsr_pkg::*; #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16,
  localparam int ROOT_WIDTH   = (DATA_WIDTH - FRACTION_BITS) / 2 + FRACTION_BITS,
  localparam int S_TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int M_TDATA_W    = ((ROOT_WIDTH + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration: iteration_count
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [ITER_W-1:0]    cfg_data,
  // input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // radicand
  // output stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [M_TDATA_W-1:0] m_tdata    // root
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  localparam logic [DATA_WIDTH-1:0] FIXED_ONE = DATA_WIDTH'(1) << FRACTION_BITS;

  state_t                state;
  logic [ITER_W-1:0]     iteration_count;
  logic [ITER_W-1:0]     step_counter;
  logic [DATA_WIDTH-1:0] estimate;
  logic [DATA_WIDTH-1:0] held_radicand;
  logic [ROOT_WIDTH-1:0] root_q;

  logic                  div_start;
  div_status_t           div_stat;
  logic [DATA_WIDTH-1:0] quotient;
  logic [DATA_WIDTH:0]   step_sum;
  logic [ROOT_WIDTH-1:0] root_sat;
  logic                  out_load;

  nsr_divider #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (held_radicand),
    .den      (estimate),
    .status   (div_stat),
    .quotient (quotient)
  );

  // a pending configuration write goes ahead of the next radicand
  assign cfg_ready = (state == ST_IDLE);
  assign s_tready  = (state == ST_IDLE) && !cfg_valid;
  assign div_start = (state == ST_DIV_START);
  assign step_sum  = {1'b0, estimate} + {1'b0, quotient};
  assign m_tdata   = M_TDATA_W'(root_q);
  // output register frees up once the previous root is taken
  assign out_load  = (state == ST_OUT) && (!m_tvalid || m_tready);

  generate
    if (ROOT_WIDTH >= DATA_WIDTH) begin : g_root_wide
      assign root_sat = ROOT_WIDTH'(estimate);
    end else begin : g_root_narrow
      assign root_sat = (estimate[DATA_WIDTH-1:ROOT_WIDTH] != '0) ? '1
                                                                  : estimate[ROOT_WIDTH-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_count <= ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      iteration_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      step_counter  <= '0;
      estimate      <= FIXED_ONE;
      held_radicand <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            held_radicand <= s_tdata[DATA_WIDTH-1:0];
            estimate      <= FIXED_ONE;
            step_counter  <= '0;
            state         <= (iteration_count == '0) ? ST_OUT : ST_DIV_START;
          end
        end
        ST_DIV_START: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            estimate     <= step_sum[DATA_WIDTH:1];
            step_counter <= step_counter + 1'b1;
            state        <= (step_counter + 1'b1 == iteration_count) ? ST_OUT : ST_DIV_START;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            root_q <= root_sat;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `NSR_ASSERT(a_start_when_free, clk, rst, !(div_start && div_stat.busy), "divider restarted")
  `NSR_ASSERT_NEXT(a_accept_blocks, clk, rst, s_tvalid && s_tready, !s_tready, "radicand overrun")
  `NSR_ASSERT_SAME(a_done_in_wait, clk, rst, div_stat.done, state == ST_DIV_WAIT, "stray done")
  `NSR_ASSERT_SAME(a_step_bound, clk, rst, div_start || state == ST_DIV_WAIT, step_counter < iteration_count, "step overrun")

endmodule

`default_nettype wire

/* rtl/nsr_divider.sv */
// ----------------------------------------------------------------------------
// nsr_divider
// bit-serial restoring fixed-point divider: (num << FRACTION_BITS) / den,
// truncated, saturated to DATA_WIDTH bits, zero when den is zero
// ----------------------------------------------------------------------------
`default_nettype none

module nsr_divider import nsr_pkg::*; #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] num,
  input  wire logic [DATA_WIDTH-1:0] den,
  output div_status_t                status,
  output logic      [DATA_WIDTH-1:0] quotient
);

  localparam int STEPS = DATA_WIDTH + FRACTION_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] num_sh;
  logic [DATA_WIDTH-1:0] divisor;
  logic                  sat;
  logic                  den_zero;

  logic [DATA_WIDTH:0]   trial;
  logic                  ge;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] rem_next;

  // one quotient bit per cycle; low fraction bits shift in as zeros
  always_comb begin
    trial    = {rem, num_sh[DATA_WIDTH-1]};
    ge       = (trial >= {1'b0, divisor});
    diff     = trial - {1'b0, divisor};
    rem_next = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(STEPS);
        rem      <= '0;
        quo      <= '0;
        sat      <= 1'b0;
        num_sh   <= num;
        divisor  <= den;
        den_zero <= (den == '0);
      end else if (busy) begin
        rem    <= rem_next;
        quo    <= {quo[DATA_WIDTH-2:0], ge};
        sat    <= sat | quo[DATA_WIDTH-1];
        num_sh <= {num_sh[DATA_WIDTH-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    status.busy = busy;
    status.done = done;
    if (den_zero) begin
      quotient = '0;
    end else if (sat) begin
      quotient = '1;
    end else begin
      quotient = quo;
    end
  end

endmodule

`default_nettype wire
